### hw/rtl/bcpa_pkg.sv
// shared constants, codes and item types for the contiguous page allocator
package bcpa_pkg;

  // page space and bitmap geometry
  localparam int PAGE_COUNT = 4096;
  localparam int MAX_RUN    = 63;
  localparam int PAGE_W     = 12;
  localparam int COUNT_W    = 7;
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int RUN_W      = $clog2(MAX_RUN + 1);
  localparam int WORDS      = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = $clog2(WORDS);

  // configuration register file
  localparam int CFG_IDX_W = 3;
  localparam int CFG_REGS  = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_DMA_FIRST      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DMA_LAST       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_FIRST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LAST    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LAST  = 3'd5;

  // request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] CLS_DMA      = 2'd0;
  localparam logic [1:0] CLS_NORMAL   = 2'd1;
  localparam logic [1:0] CLS_UNMAPPED = 2'd2;
  localparam logic [1:0] CLS_BAD      = 2'd3;

  // result codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [1:0] ST_BAD_CLASS = 2'd2;
  localparam logic [1:0] ST_NO_RUN    = 2'd3;

  typedef struct packed {
    logic               action;
    logic [1:0]         zone_class;
    logic [COUNT_W-1:0] page_count;
    logic [PAGE_W-1:0]  first_page;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] run_start;
  } out_t;

  typedef struct packed {
    logic [PAGE_W-1:0] lo;
    logic [PAGE_W-1:0] hi;
  } range_t;

  typedef struct packed {
    logic   ok;
    range_t rng;
  } zone_sel_t;

endpackage

### hw/rtl/bitmap_contiguous_page_allocator.sv
// top level of the first-fit contiguous page allocator with its class range registers
//
// One item at a time: busy is high from the cycle after start is taken until the result
// strobe, and a new item may be started in the strobe cycle. The result is on out_data for
// exactly one cycle with out_strobe high and cannot be held off. A request with a bad count,
// or an allocate with a bad class or an empty range, is answered straight from the check
// state. A free reads and writes back the word of its first page, and the next 64-page word
// too when the run crosses into it. An allocate scans the class range one 64-page bitmap
// word per cycle through the bitmap memory's read port up to the word where the run ends,
// then writes the run in the same way, into the word before that one too when the run
// starts there. An allocate that finds no run answers after reading every word of the
// range (at most 64 words). The bitmap memory is ready straight after reset: each word has
// a flag that reads it as all free until first written, so there is no clearing pass.
// Configuration writes are always taken and should only be issued while busy is low.
module bitmap_contiguous_page_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_start,
  input  bcpa_pkg::in_t                    in_data,
  output logic                             busy,
  output logic                             out_strobe,
  output bcpa_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bcpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcpa_pkg::PAGE_W-1:0]      cfg_data
);

  localparam int PW = bcpa_pkg::PAGE_W;

  logic [PW-1:0] dma_first_r, dma_last_r;
  logic [PW-1:0] normal_first_r, normal_last_r;
  logic [PW-1:0] unmapped_first_r, unmapped_last_r;

  bcpa_pkg::zone_sel_t zone_sel;

  logic                             ram_we;
  logic [bcpa_pkg::WORD_AW-1:0]     ram_waddr;
  logic [bcpa_pkg::WORD_BITS-1:0]   ram_wdata;
  logic                             ram_re;
  logic [bcpa_pkg::WORD_AW-1:0]     ram_raddr;
  logic [bcpa_pkg::WORD_BITS-1:0]   ram_rdata;

  assign cfg_ready = 1'b1;

  // class range registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dma_first_r      <= '0;
      dma_last_r       <= '0;
      normal_first_r   <= '0;
      normal_last_r    <= '0;
      unmapped_first_r <= '0;
      unmapped_last_r  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bcpa_pkg::CFG_DMA_FIRST:      dma_first_r      <= cfg_data;
        bcpa_pkg::CFG_DMA_LAST:       dma_last_r       <= cfg_data;
        bcpa_pkg::CFG_NORMAL_FIRST:   normal_first_r   <= cfg_data;
        bcpa_pkg::CFG_NORMAL_LAST:    normal_last_r    <= cfg_data;
        bcpa_pkg::CFG_UNMAPPED_FIRST: unmapped_first_r <= cfg_data;
        bcpa_pkg::CFG_UNMAPPED_LAST:  unmapped_last_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // page range of the requested class
  always_comb begin
    zone_sel = '0;
    unique case (in_data.zone_class)
      bcpa_pkg::CLS_DMA: begin
        zone_sel.ok     = 1'b1;
        zone_sel.rng.lo = dma_first_r;
        zone_sel.rng.hi = dma_last_r;
      end
      bcpa_pkg::CLS_NORMAL: begin
        zone_sel.ok     = 1'b1;
        zone_sel.rng.lo = normal_first_r;
        zone_sel.rng.hi = normal_last_r;
      end
      bcpa_pkg::CLS_UNMAPPED: begin
        zone_sel.ok     = 1'b1;
        zone_sel.rng.lo = unmapped_first_r;
        zone_sel.rng.hi = unmapped_last_r;
      end
      default: begin
        zone_sel.ok = 1'b0;
      end
    endcase
  end

  bcpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_start   (in_start),
    .in_data    (in_data),
    .zone_sel   (zone_sel),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // used-page bitmap, one 64-page word per entry
  bcpa_ram #(
    .WIDTH (bcpa_pkg::WORD_BITS),
    .DEPTH (bcpa_pkg::WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

### hw/rtl/bcpa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module bcpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/bcpa_match.sv
// free-run finder for one bitmap word, with the tail of the previous word
module bcpa_match (
  input  logic [bcpa_pkg::WORD_BITS-1:0] word,
  input  logic [bcpa_pkg::WORD_BITS-1:0] prev_free,
  input  logic [bcpa_pkg::RUN_W-1:0]     count,
  input  logic [bcpa_pkg::WORD_AW-1:0]   word_idx,
  input  bcpa_pkg::range_t               rng,
  output logic [bcpa_pkg::WORD_BITS-1:0] cur_free,
  output logic                           hit,
  output logic [bcpa_pkg::BIT_W-1:0]     pos
);

  localparam int WB = bcpa_pkg::WORD_BITS;

  logic [WB-1:0]   lo_mask;
  logic [WB-1:0]   hi_mask;
  logic [WB-1:0]   hits;
  logic [2*WB-1:0] span [bcpa_pkg::RUN_W];
  logic [2*WB-1:0] win;
  logic [bcpa_pkg::RUN_W-1:0] off;

  // free pages of this word that lie inside the class range
  always_comb begin
    lo_mask = '1;
    hi_mask = '1;
    if (word_idx == bcpa_pkg::WORD_AW'(rng.lo >> bcpa_pkg::BIT_W)) begin
      lo_mask = {WB{1'b1}} << rng.lo[bcpa_pkg::BIT_W-1:0];
    end
    if (word_idx == bcpa_pkg::WORD_AW'(rng.hi >> bcpa_pkg::BIT_W)) begin
      hi_mask = {WB{1'b1}} >> (bcpa_pkg::BIT_W'(WB - 1) - rng.hi[bcpa_pkg::BIT_W-1:0]);
    end
    cur_free = ~word & lo_mask & hi_mask;
  end

  // power-of-two free windows, then combine the ones that make up count
  always_comb begin
    span[0] = {cur_free, prev_free};
    for (int k = 1; k < bcpa_pkg::RUN_W; k++) begin
      span[k] = span[k-1] & (span[k-1] << (1 << (k - 1)));
    end
    win = '1;
    off = '0;
    for (int b = 0; b < bcpa_pkg::RUN_W; b++) begin
      if (count[b]) begin
        win = win & (span[b] << off);
        off = off + bcpa_pkg::RUN_W'(1 << b);
      end
    end
    hits = win[2*WB-1:WB];
  end

  // lowest page of this word at which a run of count free pages ends
  always_comb begin
    hit = |hits;
    pos = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (hits[i]) begin
        pos = bcpa_pkg::BIT_W'(i);
      end
    end
  end

endmodule

### hw/rtl/bcpa_ctrl.sv
// request sequencer: range scan and read-modify-write of the used-page bitmap
module bcpa_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_start,
  input  bcpa_pkg::in_t                  in_data,
  input  bcpa_pkg::zone_sel_t            zone_sel,
  output logic                           busy,
  output logic                           out_strobe,
  output bcpa_pkg::out_t                 out_data,
  output logic                           ram_we,
  output logic [bcpa_pkg::WORD_AW-1:0]   ram_waddr,
  output logic [bcpa_pkg::WORD_BITS-1:0] ram_wdata,
  output logic                           ram_re,
  output logic [bcpa_pkg::WORD_AW-1:0]   ram_raddr,
  input  logic [bcpa_pkg::WORD_BITS-1:0] ram_rdata
);

  localparam int WB = bcpa_pkg::WORD_BITS;
  localparam int AW = bcpa_pkg::WORD_AW;
  localparam int PW = bcpa_pkg::PAGE_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_AP_RD  = 3'd3;
  localparam logic [2:0] S_AP_WR1 = 3'd4;
  localparam logic [2:0] S_AP_WR2 = 3'd5;

  logic [2:0]          state_r, state_nxt;
  bcpa_pkg::in_t       item_r, item_nxt;
  bcpa_pkg::zone_sel_t zsel_r, zsel_nxt;
  bcpa_pkg::range_t    rng_r, rng_nxt;
  logic [AW-1:0]       issue_w_r, issue_w_nxt;
  logic [AW-1:0]       eval_w_r, eval_w_nxt;
  logic [AW-1:0]       last_w_r, last_w_nxt;
  logic                issuing_r, issuing_nxt;
  logic                pend_r, pend_nxt;
  logic [WB-1:0]       prev_r, prev_nxt;
  logic [PW-1:0]       ap_start_r, ap_start_nxt;
  logic                ap_set_r, ap_set_nxt;
  logic [2*WB-1:0]     mask_r, mask_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  bcpa_pkg::out_t      out_r, out_nxt;
  logic [WB-1:0]       valid_r;
  logic                rd_valid_r;

  logic [WB-1:0]            rd_word;
  logic [bcpa_pkg::RUN_W-1:0] cnt;
  logic                     cnt_bad;
  logic [PW-1:0]            hi_eff;
  logic [WB-1:0]            low_mask;
  logic [2*WB-1:0]          run_mask;
  logic [AW-1:0]            ap_w;
  logic                     ap_next_ok;
  logic [PW-1:0]            hit_start;
  logic [WB-1:0]            m_cur_free;
  logic                     m_hit;
  logic [bcpa_pkg::BIT_W-1:0] m_pos;

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  // words never written since reset read as all free
  assign rd_word = rd_valid_r ? ram_rdata : '0;

  assign cnt     = item_r.page_count[bcpa_pkg::RUN_W-1:0];
  assign cnt_bad = (item_r.page_count == '0) ||
                   (item_r.page_count > bcpa_pkg::COUNT_W'(bcpa_pkg::MAX_RUN));

  // last page of the class, clipped to the page space
  assign hi_eff = ({1'b0, zsel_r.rng.hi} >= (PW + 1)'(bcpa_pkg::PAGE_COUNT)) ?
                  PW'(bcpa_pkg::PAGE_COUNT - 1) : zsel_r.rng.hi;

  // run bits across the start word and the one after it
  assign low_mask   = (WB'(1) << cnt) - WB'(1);
  assign run_mask   = {{WB{1'b0}}, low_mask} << ap_start_r[bcpa_pkg::BIT_W-1:0];
  assign ap_w       = AW'(ap_start_r >> bcpa_pkg::BIT_W);
  assign ap_next_ok = (mask_r[2*WB-1:WB] != '0) &&
                      (({1'b0, ap_w} + (AW + 1)'(1)) < (AW + 1)'(bcpa_pkg::WORDS));

  assign hit_start = PW'({eval_w_r, m_pos}) + PW'(1) - PW'(cnt);

  bcpa_match u_match (
    .word      (rd_word),
    .prev_free (prev_r),
    .count     (cnt),
    .word_idx  (eval_w_r),
    .rng       (rng_r),
    .cur_free  (m_cur_free),
    .hit       (m_hit),
    .pos       (m_pos)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    zsel_nxt       = zsel_r;
    rng_nxt        = rng_r;
    issue_w_nxt    = issue_w_r;
    eval_w_nxt     = eval_w_r;
    last_w_nxt     = last_w_r;
    issuing_nxt    = issuing_r;
    pend_nxt       = pend_r;
    prev_nxt       = prev_r;
    ap_start_nxt   = ap_start_r;
    ap_set_nxt     = ap_set_r;
    mask_nxt       = mask_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = ap_w;
    ram_wdata      = rd_word;
    ram_re         = 1'b0;
    ram_raddr      = issue_w_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_start) begin
          item_nxt  = in_data;
          zsel_nxt  = zone_sel;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        priority if (cnt_bad) begin
          out_strobe_nxt    = 1'b1;
          out_nxt.status    = bcpa_pkg::ST_BAD_COUNT;
          out_nxt.run_start = '0;
          state_nxt         = S_IDLE;
        end else if (item_r.action == bcpa_pkg::ACT_FREE) begin
          ap_start_nxt = item_r.first_page;
          ap_set_nxt   = 1'b0;
          state_nxt    = S_AP_RD;
        end else if (!zsel_r.ok) begin
          out_strobe_nxt    = 1'b1;
          out_nxt.status    = bcpa_pkg::ST_BAD_CLASS;
          out_nxt.run_start = '0;
          state_nxt         = S_IDLE;
        end else if (zsel_r.rng.lo > hi_eff) begin
          out_strobe_nxt    = 1'b1;
          out_nxt.status    = bcpa_pkg::ST_NO_RUN;
          out_nxt.run_start = '0;
          state_nxt         = S_IDLE;
        end else begin
          rng_nxt.lo  = zsel_r.rng.lo;
          rng_nxt.hi  = hi_eff;
          issue_w_nxt = AW'(zsel_r.rng.lo >> bcpa_pkg::BIT_W);
          last_w_nxt  = AW'(hi_eff >> bcpa_pkg::BIT_W);
          issuing_nxt = 1'b1;
          pend_nxt    = 1'b0;
          prev_nxt    = '0;
          state_nxt   = S_SCAN;
        end
      end

      S_SCAN: begin
        // one word read issued per cycle, evaluated the cycle after
        if (issuing_r) begin
          ram_re      = 1'b1;
          ram_raddr   = issue_w_r;
          issue_w_nxt = issue_w_r + AW'(1);
          if (issue_w_r == last_w_r) begin
            issuing_nxt = 1'b0;
          end
        end
        pend_nxt   = issuing_r;
        eval_w_nxt = issue_w_r;
        if (pend_r) begin
          prev_nxt = m_cur_free;
          if (m_hit) begin
            ap_start_nxt = hit_start;
            ap_set_nxt   = 1'b1;
            issuing_nxt  = 1'b0;
            pend_nxt     = 1'b0;
            state_nxt    = S_AP_RD;
          end else if (eval_w_r == last_w_r) begin
            out_strobe_nxt    = 1'b1;
            out_nxt.status    = bcpa_pkg::ST_NO_RUN;
            out_nxt.run_start = '0;
            state_nxt         = S_IDLE;
          end
        end
      end

      S_AP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ap_w;
        mask_nxt  = run_mask;
        state_nxt = S_AP_WR1;
      end

      S_AP_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = ap_w;
        ram_wdata = ap_set_r ? (rd_word | mask_r[WB-1:0]) : (rd_word & ~mask_r[WB-1:0]);
        if (ap_next_ok) begin
          ram_re    = 1'b1;
          ram_raddr = ap_w + AW'(1);
          state_nxt = S_AP_WR2;
        end else begin
          out_strobe_nxt    = 1'b1;
          out_nxt.status    = bcpa_pkg::ST_OK;
          out_nxt.run_start = ap_set_r ? ap_start_r : '0;
          state_nxt         = S_IDLE;
        end
      end

      S_AP_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = ap_w + AW'(1);
        ram_wdata = ap_set_r ? (rd_word | mask_r[2*WB-1:WB]) :
                               (rd_word & ~mask_r[2*WB-1:WB]);
        out_strobe_nxt    = 1'b1;
        out_nxt.status    = bcpa_pkg::ST_OK;
        out_nxt.run_start = ap_set_r ? ap_start_r : '0;
        state_nxt         = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issuing_r    <= 1'b0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      valid_r      <= '0;
      rd_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issuing_r    <= issuing_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid_r <= valid_r[ram_raddr];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    zsel_r     <= zsel_nxt;
    rng_r      <= rng_nxt;
    issue_w_r  <= issue_w_nxt;
    eval_w_r   <= eval_w_nxt;
    last_w_r   <= last_w_nxt;
    prev_r     <= prev_nxt;
    ap_start_r <= ap_start_nxt;
    ap_set_r   <= ap_set_nxt;
    mask_r     <= mask_nxt;
    out_r      <= out_nxt;
  end

  // an accepted item always makes the sequencer busy in the following cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_start && !busy) |=> busy)
    else $error("accepted item did not start the sequencer");

  // read and write of the same word never meet in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write of the same bitmap word in one cycle");

  // a result only appears as the sequencer returns to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (state_r == S_IDLE))
    else $error("result strobe while sequencer still busy");

  // failed requests carry no start page
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (out_r.status != bcpa_pkg::ST_OK)) |-> (out_r.run_start == '0))
    else $error("failed request returned a start page");

  // the scan never evaluates a word beyond the end of the range
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && pend_r) |-> (eval_w_r <= last_w_r))
    else $error("scan evaluated a word past the range");

endmodule

### sim/tb_bitmap_contiguous_page_allocator.sv
// testbench for the bitmap first-fit contiguous page allocator: directed and random requests

// page ledger: predicts every reply and checks replies in order
class page_ledger;
  bit page_used [bcpa_pkg::PAGE_COUNT];
  int zone_first [3];
  int zone_last [3];
  bcpa_pkg::out_t due_replies [$];
  int errors;

  function new();
    foreach (page_used[p]) page_used[p] = 1'b0;
    zone_first[bcpa_pkg::CLS_DMA]      = 0;
    zone_last[bcpa_pkg::CLS_DMA]       = 0;
    zone_first[bcpa_pkg::CLS_NORMAL]   = 0;
    zone_last[bcpa_pkg::CLS_NORMAL]    = 0;
    zone_first[bcpa_pkg::CLS_UNMAPPED] = 0;
    zone_last[bcpa_pkg::CLS_UNMAPPED]  = 4095;
    errors = 0;
  endfunction

  // register write; unknown indexes are dropped
  function void set_reg(logic [bcpa_pkg::CFG_IDX_W-1:0] idx, logic [bcpa_pkg::PAGE_W-1:0] val);
    case (idx)
      bcpa_pkg::CFG_DMA_FIRST:      zone_first[bcpa_pkg::CLS_DMA] = int'(val);
      bcpa_pkg::CFG_DMA_LAST:       zone_last[bcpa_pkg::CLS_DMA] = int'(val);
      bcpa_pkg::CFG_NORMAL_FIRST:   zone_first[bcpa_pkg::CLS_NORMAL] = int'(val);
      bcpa_pkg::CFG_NORMAL_LAST:    zone_last[bcpa_pkg::CLS_NORMAL] = int'(val);
      bcpa_pkg::CFG_UNMAPPED_FIRST: zone_first[bcpa_pkg::CLS_UNMAPPED] = int'(val);
      bcpa_pkg::CFG_UNMAPPED_LAST:  zone_last[bcpa_pkg::CLS_UNMAPPED] = int'(val);
      default: ;
    endcase
  endfunction

  // allocate or release a run and work out the reply
  function bcpa_pkg::out_t grant_or_release(bcpa_pkg::in_t req);
    bcpa_pkg::out_t rep;
    int lo, hi, run, p, n, i, start;
    bit found;
    rep.status = bcpa_pkg::ST_OK;
    rep.run_start = '0;
    n = int'(req.page_count);
    found = 1'b0;
    start = 0;
    lo = 0;
    hi = -1;
    if (n == 0 || n > bcpa_pkg::MAX_RUN) begin
      rep.status = bcpa_pkg::ST_BAD_COUNT;
    end else if (req.action == bcpa_pkg::ACT_FREE) begin
      // pages past the end of the space are skipped
      for (i = 0; i < n; i++) begin
        p = int'(req.first_page) + i;
        if (p < bcpa_pkg::PAGE_COUNT) page_used[p] = 1'b0;
      end
    end else begin
      case (req.zone_class)
        bcpa_pkg::CLS_DMA, bcpa_pkg::CLS_NORMAL, bcpa_pkg::CLS_UNMAPPED: begin
          lo = zone_first[req.zone_class];
          hi = zone_last[req.zone_class];
        end
        default: rep.status = bcpa_pkg::ST_BAD_CLASS;
      endcase
      if (rep.status == bcpa_pkg::ST_OK) begin
        if (hi >= bcpa_pkg::PAGE_COUNT) hi = bcpa_pkg::PAGE_COUNT - 1;
        // lowest fitting run, an inverted range never fits
        run = 0;
        for (p = lo; p <= hi && !found; p++) begin
          if (page_used[p]) begin
            run = 0;
          end else begin
            run++;
            if (run == n) begin
              start = p + 1 - n;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          for (i = 0; i < n; i++) page_used[start + i] = 1'b1;
          rep.run_start = bcpa_pkg::PAGE_W'(start);
        end else begin
          rep.status = bcpa_pkg::ST_NO_RUN;
        end
      end
    end
    return rep;
  endfunction

  function bcpa_pkg::out_t note_request(bcpa_pkg::in_t req);
    bcpa_pkg::out_t rep;
    rep = grant_or_release(req);
    due_replies.push_back(rep);
    return rep;
  endfunction

  function void check_reply(bcpa_pkg::out_t got);
    bcpa_pkg::out_t want;
    if (due_replies.size() == 0) begin
      $display("%0t: reply with none outstanding: status %0d run_start %0d",
               $time, got.status, got.run_start);
      errors++;
      return;
    end
    want = due_replies.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, got.status);
      errors++;
    end
    if (got.run_start !== want.run_start) begin
      $display("%0t: run_start mismatch: expected %0d actual %0d",
               $time, want.run_start, got.run_start);
      errors++;
    end
  endfunction

  function int pending();
    return due_replies.size();
  endfunction
endclass

module tb_bitmap_contiguous_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bcpa_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 85;
  localparam int TAIL_CYCLES = 80;

  // indexes beyond the register file
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct {
    int first;
    int n;
  } page_run_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_start;
  in_t                  in_data;
  logic                 busy;
  logic                 out_strobe;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAGE_W-1:0]    cfg_data;

  page_ledger ledger;
  page_run_t  live_runs [$];
  bit         gaps_on;
  int         quiet_cycles;

  bitmap_contiguous_page_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_start   (in_start),
    .in_data    (in_data),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // reply checker
  always @(posedge clk) begin
    if (rst_n && out_strobe) ledger.check_reply(out_data);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic in_t mk(logic act, logic [1:0] zone, logic [COUNT_W-1:0] cnt,
                             logic [PAGE_W-1:0] first);
    in_t req;
    req.action = act;
    req.zone_class = zone;
    req.page_count = cnt;
    req.first_page = first;
    return req;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly small counts, some up to the limit, a few out of range
  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return COUNT_W'($urandom_range(MAX_RUN + 1, 127));
    if (r < 70) return COUNT_W'($urandom_range(1, 8));
    return COUNT_W'($urandom_range(1, MAX_RUN));
  endfunction

  // random item: allocations, frees of live runs, and noise
  function automatic in_t make_request();
    in_t req;
    int k, n;
    req.first_page = PAGE_W'($urandom);
    req.zone_class = 2'($urandom);
    if ($urandom_range(0, 99) < 56) begin
      req.action = ACT_ALLOC;
      req.zone_class = ($urandom_range(0, 99) < 92) ? 2'($urandom_range(0, 2)) : CLS_BAD;
      req.page_count = pick_count();
    end else begin
      req.action = ACT_FREE;
      if (live_runs.size() > 0 && $urandom_range(0, 99) < 80) begin
        k = $urandom_range(0, live_runs.size() - 1);
        n = live_runs[k].n;
        req.first_page = PAGE_W'(live_runs[k].first);
        req.page_count = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(1, n))
                                                     : COUNT_W'(n);
        live_runs.delete(k);
      end else begin
        req.page_count = pick_count();
      end
    end
    return req;
  endfunction

  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_start <= 1'b0;
    end
  endtask

  // present one item and hold it until taken
  task automatic send_request(in_t req);
    out_t rep;
    hold_off(pick_gap());
    @(negedge clk);
    in_start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy !== 1'b0);
    rep = ledger.note_request(req);
    if (req.action == ACT_ALLOC && rep.status == ST_OK)
      live_runs.push_back('{int'(rep.run_start), int'(req.page_count)});
  endtask

  task automatic wait_empty();
    @(negedge clk);
    in_start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAGE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    ledger.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_ranges(int dl, int dh, int nl, int nh, int ul, int uh);
    write_reg(CFG_DMA_FIRST, PAGE_W'(dl));
    write_reg(CFG_DMA_LAST, PAGE_W'(dh));
    write_reg(CFG_NORMAL_FIRST, PAGE_W'(nl));
    write_reg(CFG_NORMAL_LAST, PAGE_W'(nh));
    write_reg(CFG_UNMAPPED_FIRST, PAGE_W'(ul));
    write_reg(CFG_UNMAPPED_LAST, PAGE_W'(uh));
  endtask

  // class ranges for one random phase
  task automatic pick_ranges(int mode);
    int lo [3];
    int hi [3];
    case (mode)
      0: set_ranges(0, 4095, 0, 4095, 0, 4095);
      1: set_ranges(0, 0, 4095, 4095, 0, 4095);
      2: begin
        foreach (lo[z]) begin
          lo[z] = $urandom_range(0, 4095);
          hi[z] = lo[z] + $urandom_range(0, 700);
          if (hi[z] > 4095) hi[z] = 4095;
        end
        set_ranges(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
      end
      3: set_ranges(0, 127, 128, 511, 3900, 4095);
      default: begin
        // any values, often inverted
        foreach (lo[z]) begin
          lo[z] = $urandom_range(0, 4095);
          hi[z] = $urandom_range(0, 4095);
        end
        set_ranges(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
      end
    endcase
    if ($urandom_range(0, 1) == 1)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, PAGE_W'($urandom));
  endtask

  initial begin
    ledger = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gaps_on = 1'b1;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset ranges: dma and normal hold page 0 only, unmapped spans everything
    send_request(mk(ACT_ALLOC, CLS_UNMAPPED, 1, 4095));
    send_request(mk(ACT_ALLOC, CLS_UNMAPPED, 63, 0));
    send_request(mk(ACT_ALLOC, CLS_DMA, 1, 0));
    send_request(mk(ACT_ALLOC, CLS_NORMAL, 1, 0));
    send_request(mk(ACT_ALLOC, CLS_BAD, 5, 0));
    // count is checked ahead of the class
    send_request(mk(ACT_ALLOC, CLS_BAD, 0, 0));
    send_request(mk(ACT_ALLOC, CLS_UNMAPPED, 64, 0));
    send_request(mk(ACT_ALLOC, CLS_DMA, 127, 4095));
    send_request(mk(ACT_FREE, CLS_BAD, 0, 4095));
    send_request(mk(ACT_FREE, CLS_DMA, 127, 0));
    // free ignores the class
    send_request(mk(ACT_FREE, CLS_BAD, 1, 0));
    send_request(mk(ACT_ALLOC, CLS_DMA, 1, 4095));
    // free running off the end, then free of pages already free
    send_request(mk(ACT_FREE, CLS_NORMAL, 63, 4090));
    send_request(mk(ACT_FREE, CLS_UNMAPPED, 20, 3000));
    send_request(mk(ACT_FREE, CLS_DMA, 63, 1));

    // inverted dma range, single top page for normal, last 63 pages for unmapped
    wait_empty();
    set_ranges(100, 50, 4095, 4095, 4033, 4095);
    write_reg(CFG_SPARE_B, '1);
    send_request(mk(ACT_ALLOC, CLS_DMA, 1, 0));
    send_request(mk(ACT_ALLOC, CLS_NORMAL, 1, 0));
    send_request(mk(ACT_ALLOC, CLS_NORMAL, 1, 0));
    send_request(mk(ACT_ALLOC, CLS_UNMAPPED, 63, 0));
    send_request(mk(ACT_ALLOC, CLS_UNMAPPED, 62, 0));
    send_request(mk(ACT_FREE, CLS_BAD, 63, 4033));
    send_request(mk(ACT_ALLOC, CLS_UNMAPPED, 63, 0));
    send_request(mk(ACT_FREE, CLS_UNMAPPED, 63, 4032));

    // random phases, each with its own class ranges
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_empty();
      pick_ranges(phase % 5);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 3) wait_empty();
        send_request(make_request());
      end
    end

    wait_empty();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
